### hw/rtl/bpa_pkg.sv
`timescale 1ns / 1ps
// bpa_pkg: shared types, operation codes and bit helpers for the bitmap page allocator
// used by bitmap_page_allocator and bpa_checker; no dependencies
package bpa_pkg;

   localparam int PAGES_DEF      = 4096;
   localparam int PAGE_BYTES_DEF = 4096;

   // one map word holds the used bits of this many pages
   localparam int WORD_BITS  = 64;
   localparam int WORD_SHIFT = 6;
   localparam int POS_W      = 7;

   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_FREE    = 2'd1;
   localparam logic [1:0] OP_RESERVE = 2'd2;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] byte_address;
      logic [12:0] page_count;
   } req_type;

   typedef struct packed {
      logic [23:0] run_address;
      logic        ok;
      logic [12:0] pages_used;
      logic [12:0] pages_free;
   } rsp_type;

   // index of lowest set bit, WORD_BITS when none
   function automatic logic [POS_W-1:0] ctz_word(input logic [WORD_BITS-1:0] v);
      logic [POS_W-1:0] r;
      r = POS_W'(WORD_BITS);
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = POS_W'(i);
         end
      end
      return r;
   endfunction

   function automatic logic [POS_W-1:0] popcount_word(input logic [WORD_BITS-1:0] v);
      logic [POS_W-1:0] r;
      r = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         r = r + POS_W'(v[i]);
      end
      return r;
   endfunction

   // mask with the n lowest bits set, n up to WORD_BITS
   function automatic logic [WORD_BITS-1:0] low_ones(input logic [POS_W-1:0] n);
      logic [WORD_BITS-1:0] r;
      if (n >= POS_W'(WORD_BITS)) begin
         r = '1;
      end else begin
         r = (WORD_BITS'(1) << n) - WORD_BITS'(1);
      end
      return r;
   endfunction

endpackage

### hw/rtl/bpa_ram.sv
`timescale 1ns / 1ps
// bpa_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module bpa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/bitmap_page_allocator.sv
`timescale 1ns / 1ps
// bitmap_page_allocator: first-fit page allocator over a used-page bitmap in RAM
// depends on bpa_pkg and bpa_ram
//
//  channel   ports                        beat taken when
//  --------  ---------------------------  -----------------------------------
//  request   start, busy, req_item        rising edge with start high, busy low
//  response  rsp_valid, rsp_item          every cycle rsp_valid is high
//  csr       csr_we, csr_wdata            rising edge with csr_we high
//
// after reset the map is cleared one word a cycle, with busy high
// allocate: each map word is fetched, then scanned one free or used stretch at a time
//   by the shared shift / trailing-zero unit; the found run is then marked word by word
//   through the same path as free and reserve
// free and reserve: each touched word is fetched, merged, then written and counted
// the response is a one-cycle strobe; the receiver cannot stall it
module bitmap_page_allocator #(
   parameter int PAGES      = bpa_pkg::PAGES_DEF,
   parameter int PAGE_BYTES = bpa_pkg::PAGE_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bpa_pkg::req_type req_item,
   output logic             rsp_valid,
   output bpa_pkg::rsp_type rsp_item,
   input  logic             csr_we,
   input  logic [12:0]      csr_wdata
);

   import bpa_pkg::*;

   // map geometry
   localparam int WORDS  = (PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int WI_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int OFFS_W = $clog2(PAGE_BYTES);
   localparam int CNT_W  = $clog2(PAGES + 1);
   // width of an active page total
   localparam int TW     = (CNT_W > 13) ? CNT_W : 13;
   // width of page positions: start page plus count, and totals
   localparam int PW0    = ((32 - OFFS_W) > TW) ? (32 - OFFS_W) : TW;
   localparam int PW     = PW0 + 2;
   localparam int RUN_W  = 13;

   // sequencer states
   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_AFETCH = 4'd2;
   localparam logic [3:0] S_AWAIT  = 4'd3;
   localparam logic [3:0] S_ASCAN  = 4'd4;
   localparam logic [3:0] S_MFETCH = 4'd5;
   localparam logic [3:0] S_MMERGE = 4'd6;
   localparam logic [3:0] S_MWRITE = 4'd7;
   localparam logic [3:0] S_DONE   = 4'd8;

   logic [3:0]           state_ff, state_in;
   logic [12:0]          page_total_ff, page_total_in;
   logic [CNT_W-1:0]     used_ff, used_in;
   logic [WI_W-1:0]      wi_ff, wi_in;
   logic [1:0]           op_ff, op_in;
   logic [12:0]          cnt_ff, cnt_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic                 skip_ff, skip_in;
   logic [RUN_W-1:0]     run_ff, run_in;
   logic [PW-1:0]        first_ff, first_in;
   logic [WORD_BITS-1:0] ew_ff, ew_in;
   logic [PW-1:0]        mstart_ff, mstart_in;
   logic [PW-1:0]        mlim_ff, mlim_in;
   logic [WORD_BITS-1:0] wdata_ff, wdata_in;
   logic [WORD_BITS-1:0] chg_ff, chg_in;
   logic                 ok_ff, ok_in;
   logic [23:0]          addr_ff, addr_in;

   // active total, saturated at PAGES
   logic [TW-1:0]        tot;
   logic [PW-1:0]        tot_p;
   logic [PW-1:0]        base;
   logic                 accept;

   // request decode
   logic [PW-1:0]        req_start_pg;
   logic [PW-1:0]        req_end_pg;
   logic [PW-1:0]        req_lim;

   // ram port
   logic                 ram_we;
   logic [WORD_BITS-1:0] ram_wdata;
   logic [WORD_BITS-1:0] ram_rdata;

   // shared scan unit: shift then trailing-zero count
   logic [WORD_BITS-1:0] scan_src;
   logic [WORD_BITS-1:0] scan_sh;
   logic [POS_W-1:0]     scan_len;
   logic [POS_W-1:0]     scan_end;
   logic [RUN_W:0]       run_sum;
   logic [PW-1:0]        hit_start;
   logic [PW+OFFS_W-1:0] hit_bytes;
   logic                 last_word_alloc;

   // per-word bounds for tail masking and run marking
   logic [PW-1:0]        tot_off;
   logic [PW-1:0]        lo_off;
   logic [PW-1:0]        hi_off;
   logic [POS_W-1:0]     tot_hi;
   logic [POS_W-1:0]     m_lo;
   logic [POS_W-1:0]     m_hi;
   logic [WORD_BITS-1:0] m_mask;
   logic [WORD_BITS-1:0] page0_mask;
   logic [POS_W-1:0]     chg_cnt;

   assign tot    = (TW'(page_total_ff) > TW'(PAGES)) ? TW'(PAGES) : TW'(page_total_ff);
   assign tot_p  = PW'(tot);
   assign base   = PW'({wi_ff, {WORD_SHIFT{1'b0}}});
   assign accept = start && !busy;

   assign req_start_pg = PW'(req_item.byte_address >> OFFS_W);
   assign req_end_pg   = req_start_pg + PW'(req_item.page_count);
   assign req_lim      = (req_end_pg < tot_p) ? req_end_pg : tot_p;

   // tail of the map past the active total reads as used, and so does page zero
   assign tot_off    = tot_p - base;
   assign tot_hi     = (tot_p <= base) ? '0 :
                       (tot_off >= PW'(WORD_BITS)) ? POS_W'(WORD_BITS) : tot_off[POS_W-1:0];
   assign page0_mask = (wi_ff == '0) ? WORD_BITS'(1) : '0;

   // bits of the current word inside [mstart, mlim)
   assign lo_off = mstart_ff - base;
   assign hi_off = mlim_ff - base;
   assign m_lo   = (mstart_ff > base) ? lo_off[POS_W-1:0] : '0;
   assign m_hi   = (hi_off >= PW'(WORD_BITS)) ? POS_W'(WORD_BITS) : hi_off[POS_W-1:0];
   assign m_mask = low_ones(m_hi) & ~low_ones(m_lo);

   // free stretch on the free pass, used stretch on the skip pass
   assign scan_src = skip_ff ? ~ew_ff : ew_ff;
   assign scan_sh  = scan_src >> pos_ff;
   assign scan_len = (scan_sh == '0) ? (POS_W'(WORD_BITS) - pos_ff) : ctz_word(scan_sh);
   assign scan_end = pos_ff + scan_len;
   assign run_sum  = (RUN_W + 1)'(run_ff) + (RUN_W + 1)'(scan_len);

   assign hit_start = (run_ff == '0) ? (base + PW'(pos_ff)) : first_ff;
   assign hit_bytes = (PW + OFFS_W)'(hit_start) << OFFS_W;

   assign last_word_alloc = (base + PW'(WORD_BITS)) >= tot_p;
   assign chg_cnt         = popcount_word(chg_ff);

   always_comb begin
      state_in      = state_ff;
      page_total_in = page_total_ff;
      used_in       = used_ff;
      wi_in         = wi_ff;
      op_in         = op_ff;
      cnt_in        = cnt_ff;
      pos_in        = pos_ff;
      skip_in       = skip_ff;
      run_in        = run_ff;
      first_in      = first_ff;
      ew_in         = ew_ff;
      mstart_in     = mstart_ff;
      mlim_in       = mlim_ff;
      wdata_in      = wdata_ff;
      chg_in        = chg_ff;
      ok_in         = ok_ff;
      addr_in       = addr_ff;
      ram_we        = 1'b0;
      ram_wdata     = wdata_ff;

      if (csr_we) begin
         page_total_in = csr_wdata;
      end

      unique case (state_ff)
         S_CLEAR: begin
            // post-reset sweep, one word a cycle
            ram_we    = 1'b1;
            ram_wdata = '0;
            if (wi_ff == WI_W'(WORDS - 1)) begin
               state_in = S_IDLE;
            end else begin
               wi_in = wi_ff + WI_W'(1);
            end
         end

         S_IDLE: begin
            if (accept) begin
               op_in   = req_item.operation;
               cnt_in  = req_item.page_count;
               addr_in = '0;
               unique case (req_item.operation)
                  OP_ALLOC: begin
                     ok_in   = 1'b0;
                     wi_in   = '0;
                     pos_in  = '0;
                     skip_in = 1'b0;
                     run_in  = '0;
                     // nothing to find for an empty request or a total below two pages
                     if (req_item.page_count == '0 || tot <= TW'(1)) begin
                        state_in = S_DONE;
                     end else begin
                        state_in = S_AFETCH;
                     end
                  end
                  OP_FREE, OP_RESERVE: begin
                     ok_in     = 1'b1;
                     mstart_in = req_start_pg;
                     mlim_in   = req_lim;
                     wi_in     = req_start_pg[WI_W+WORD_SHIFT-1:WORD_SHIFT];
                     if (req_start_pg >= req_lim) begin
                        state_in = S_DONE;
                     end else begin
                        state_in = S_MFETCH;
                     end
                  end
                  default: begin
                     ok_in    = 1'b0;
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_AFETCH: begin
            state_in = S_AWAIT;
         end

         S_AWAIT: begin
            ew_in    = ram_rdata | ~low_ones(tot_hi) | page0_mask;
            state_in = S_ASCAN;
         end

         S_ASCAN: begin
            if (!skip_ff) begin
               if (run_sum >= (RUN_W + 1)'(cnt_ff)) begin
                  // run complete: mark it used through the marking path
                  ok_in     = 1'b1;
                  addr_in   = hit_bytes[23:0];
                  mstart_in = hit_start;
                  mlim_in   = hit_start + PW'(cnt_ff);
                  wi_in     = hit_start[WI_W+WORD_SHIFT-1:WORD_SHIFT];
                  state_in  = S_MFETCH;
               end else begin
                  if (run_ff == '0 && scan_len != '0) begin
                     first_in = base + PW'(pos_ff);
                  end
                  if (scan_end == POS_W'(WORD_BITS)) begin
                     // free stretch reaches the word end, carry the run over
                     run_in = run_sum[RUN_W-1:0];
                     pos_in = '0;
                     if (last_word_alloc) begin
                        state_in = S_DONE;
                     end else begin
                        wi_in    = wi_ff + WI_W'(1);
                        state_in = S_AFETCH;
                     end
                  end else begin
                     run_in  = '0;
                     pos_in  = scan_end;
                     skip_in = 1'b1;
                  end
               end
            end else begin
               skip_in = 1'b0;
               if (scan_end == POS_W'(WORD_BITS)) begin
                  pos_in = '0;
                  if (last_word_alloc) begin
                     state_in = S_DONE;
                  end else begin
                     wi_in    = wi_ff + WI_W'(1);
                     state_in = S_AFETCH;
                  end
               end else begin
                  pos_in = scan_end;
               end
            end
         end

         S_MFETCH: begin
            state_in = S_MMERGE;
         end

         S_MMERGE: begin
            if (op_ff == OP_FREE) begin
               wdata_in = ram_rdata & ~m_mask;
            end else begin
               wdata_in = ram_rdata | m_mask;
            end
            chg_in   = ram_rdata & m_mask;
            if (op_ff != OP_FREE) begin
               chg_in = ~ram_rdata & m_mask;
            end
            state_in = S_MWRITE;
         end

         S_MWRITE: begin
            ram_we = 1'b1;
            // count only bits that really flipped
            if (op_ff == OP_FREE) begin
               used_in = used_ff - CNT_W'(chg_cnt);
            end else begin
               used_in = used_ff + CNT_W'(chg_cnt);
            end
            if ((base + PW'(WORD_BITS)) < mlim_ff) begin
               wi_in    = wi_ff + WI_W'(1);
               state_in = S_MFETCH;
            end else begin
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         page_total_ff <= '0;
         used_ff       <= '0;
         wi_ff         <= '0;
      end else begin
         state_ff      <= state_in;
         page_total_ff <= page_total_in;
         used_ff       <= used_in;
         wi_ff         <= wi_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      cnt_ff    <= cnt_in;
      pos_ff    <= pos_in;
      skip_ff   <= skip_in;
      run_ff    <= run_in;
      first_ff  <= first_in;
      ew_ff     <= ew_in;
      mstart_ff <= mstart_in;
      mlim_ff   <= mlim_in;
      wdata_ff  <= wdata_in;
      chg_ff    <= chg_in;
      ok_ff     <= ok_in;
      addr_ff   <= addr_in;
   end

   // used-page bitmap, one word per 64 pages
   bpa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (WORDS),
      .AW    (WI_W)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wi_ff),
      .wr_data (ram_wdata),
      .rd_addr (wi_ff),
      .rd_data (ram_rdata)
   );

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);

   always_comb begin
      rsp_item.run_address = addr_ff;
      rsp_item.ok          = ok_ff;
      rsp_item.pages_used  = 13'(used_ff);
      rsp_item.pages_free  = (tot > TW'(used_ff)) ? 13'(tot - TW'(used_ff)) : 13'd0;
   end

endmodule

### hw/rtl/bpa_checker.sv
`timescale 1ns / 1ps
// bpa_checker: port-level assertions for the bitmap page allocator, bound to the top
// depends on bpa_pkg and bitmap_page_allocator
module bpa_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input bpa_pkg::rsp_type rsp_item
);

   import bpa_pkg::*;

   // one strobe per request, never two in a row
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for more than one cycle");

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request taken but block not busy");

   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response shown while idle");

   a_fail_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_item.ok) |-> (rsp_item.run_address == 24'd0))
      else $error("failed beat carries a nonzero address");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);

### test/tb_bitmap_page_allocator.sv
`timescale 1ns / 1ps
// tb_bitmap_page_allocator: self-checking bench for the first-fit bitmap page allocator
// depends on bpa_pkg and bitmap_page_allocator; a directed table, then random phases
module tb_bitmap_page_allocator;
   import bpa_pkg::*;

   localparam int NUM_PAGES      = PAGES_DEF;
   localparam int BYTES_PER_PAGE = PAGE_BYTES_DEF;
   localparam int MAX_GAP        = 17;
   localparam int PHASES         = 10;
   localparam int PHASE_BEATS    = 115;
   localparam int RANDOM_PHASE   = 7;
   // worst allocate scan on a fragmented map plus marking, with margin
   localparam int DRAIN_CYCLES   = 4500;
   localparam logic [1:0] OP_UNKNOWN = 2'd3;

   // page totals per random phase: extremes, saturation, tiny and odd totals
   localparam logic [12:0] PHASE_TOTAL [PHASES] = '{
      13'd4096, 13'd8191, 13'd64, 13'd0, 13'd1000, 13'd4096, 13'd65, 13'd0, 13'd2, 13'd300
   };

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_item;
   logic        rsp_valid;
   rsp_type     rsp_item;
   logic        csr_we;
   logic [12:0] csr_wdata;

   bitmap_page_allocator i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // mirror of the allocator state
   logic [NUM_PAGES-1:0] page_map;
   logic [12:0]          mirror_used;
   logic [12:0]          total_reg;

   // runs handed out by allocate, kept so that most frees are well formed
   typedef struct {
      int unsigned first_page;
      int unsigned pages;
   } run_type;
   run_type live_runs[$];

   // response beats still owed by the block, oldest first
   rsp_type pending_rsps[$];
   int      mismatch_count;

   // one row of the directed table: either a csr write or a request beat
   typedef struct {
      bit          is_cfg;
      logic [12:0] cfg_value;
      req_type     req;
      bit          typed;
      rsp_type     rsp;
   } dir_row_type;
   dir_row_type dir_rows[$];

   // ------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------

   // page total as the block uses it, saturated at the map size
   function automatic int unsigned active_pages();
      return (total_reg > 13'(NUM_PAGES)) ? NUM_PAGES : int'(total_reg);
   endfunction

   // the used count only moves on a real bit change
   function automatic void mark_page(int unsigned pg, logic val);
      if (val && !page_map[pg]) begin
         page_map[pg] = 1'b1;
         mirror_used  = mirror_used + 13'd1;
      end else if (!val && page_map[pg]) begin
         page_map[pg] = 1'b0;
         mirror_used  = mirror_used - 13'd1;
      end
   endfunction

   // lowest run of count free pages from page 1, -1 when none
   function automatic int find_first_fit(int unsigned count);
      int unsigned total;
      int unsigned run;
      int unsigned first;
      total = active_pages();
      run   = 0;
      first = 0;
      if (count == 0) begin
         return -1;
      end
      for (int unsigned p = 1; p < total; p++) begin
         if (page_map[p]) begin
            run = 0;
         end else begin
            if (run == 0) begin
               first = p;
            end
            run++;
            if (run == count) begin
               return int'(first);
            end
         end
      end
      return -1;
   endfunction

   function automatic rsp_type apply_page_op(req_type r);
      rsp_type     o;
      int unsigned total;
      int unsigned first_pg;
      int          found;
      o     = '0;
      total = active_pages();
      case (r.operation)
         OP_ALLOC: begin
            found = find_first_fit(r.page_count);
            if (found >= 0) begin
               for (int unsigned i = 0; i < r.page_count; i++) begin
                  mark_page(found + i, 1'b1);
               end
               o.run_address = 24'(found * BYTES_PER_PAGE);
               o.ok          = 1'b1;
            end
         end
         OP_FREE, OP_RESERVE: begin
            first_pg = r.byte_address / BYTES_PER_PAGE;
            // pages at or above the total are skipped
            for (int unsigned i = 0; i < r.page_count; i++) begin
               if (first_pg + i < total) begin
                  mark_page(first_pg + i, r.operation == OP_RESERVE);
               end
            end
            o.ok = 1'b1;
         end
         default: begin
         end
      endcase
      o.pages_used = mirror_used;
      // free count saturates at zero when the total drops below marked pages
      o.pages_free = (total > mirror_used) ? 13'(total - mirror_used) : 13'd0;
      return o;
   endfunction

   // ------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------

   task automatic report_mismatch(string what, longint got, longint want);
      mismatch_count++;
      $display("%0t ns: mismatch on %s, got %0h want %0h", $time, what, got, want);
   endtask

   // every cycle with rsp_valid high carries one beat; compare with the oldest owed one
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsps.size() == 0) begin
            report_mismatch("response beat with none owed", rsp_item, 0);
         end else begin
            want = pending_rsps.pop_front();
            if (rsp_item.run_address !== want.run_address) begin
               report_mismatch("run_address", rsp_item.run_address, want.run_address);
            end
            if (rsp_item.ok !== want.ok) begin
               report_mismatch("ok", rsp_item.ok, want.ok);
            end
            if (rsp_item.pages_used !== want.pages_used) begin
               report_mismatch("pages_used", rsp_item.pages_used, want.pages_used);
            end
            if (rsp_item.pages_free !== want.pages_free) begin
               report_mismatch("pages_free", rsp_item.pages_free, want.pages_free);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // driving: all tasks enter and leave just after a falling edge
   // ------------------------------------------------------------------

   // one request beat after gap idle cycles; start stays high across back-to-back beats
   task automatic send_beat(req_type r, bit typed, rsp_type typed_rsp, int unsigned gap);
      rsp_type predicted;
      run_type rn;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start    <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
      // beat taken at this edge: advance the mirror and owe a response
      predicted = apply_page_op(r);
      pending_rsps.push_back(typed ? typed_rsp : predicted);
      if (r.operation == OP_ALLOC && predicted.ok) begin
         rn.first_page = predicted.run_address / BYTES_PER_PAGE;
         rn.pages      = r.page_count;
         live_runs.push_back(rn);
      end
      @(negedge clock);
   endtask

   // drop start and wait until every owed beat has come and the block is free
   task automatic wait_idle();
      start <= 1'b0;
      do @(posedge clock); while (pending_rsps.size() != 0 || busy);
      @(negedge clock);
   endtask

   task automatic write_total(logic [12:0] value);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      total_reg = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // directed table rows
   // ------------------------------------------------------------------

   function automatic void add_cfg(logic [12:0] value);
      dir_row_type row;
      row           = '{default: '0};
      row.is_cfg    = 1'b1;
      row.cfg_value = value;
      dir_rows.push_back(row);
   endfunction

   function automatic void add_beat(logic [1:0] op, logic [31:0] addr, logic [12:0] count);
      dir_row_type row;
      row                  = '{default: '0};
      row.req.operation    = op;
      row.req.byte_address = addr;
      row.req.page_count   = count;
      dir_rows.push_back(row);
   endfunction

   // a beat whose response can be read straight off the spec
   function automatic void add_checked(logic [1:0] op, logic [31:0] addr, logic [12:0] count,
                                       logic [23:0] raddr, logic ok, logic [12:0] used,
                                       logic [12:0] avail);
      dir_row_type row;
      row                  = '{default: '0};
      row.req.operation    = op;
      row.req.byte_address = addr;
      row.req.page_count   = count;
      row.typed            = 1'b1;
      row.rsp.run_address  = raddr;
      row.rsp.ok           = ok;
      row.rsp.pages_used   = used;
      row.rsp.pages_free   = avail;
      dir_rows.push_back(row);
   endfunction

   // ------------------------------------------------------------------
   // random request mix
   // ------------------------------------------------------------------

   function automatic req_type random_req();
      req_type     r;
      run_type     rn;
      int unsigned pick;
      int unsigned sz;
      int unsigned idx;
      int unsigned pg;
      r.operation    = OP_ALLOC;
      r.byte_address = $urandom();
      r.page_count   = 13'($urandom_range(1, 8));
      pick           = $urandom_range(0, 99);
      if (pick < 45) begin
         // allocate: mostly small runs, a few long ones, rarely any count at all
         sz = $urandom_range(0, 99);
         if (sz < 70) begin
            r.page_count = 13'($urandom_range(1, 8));
         end else if (sz < 90) begin
            r.page_count = 13'($urandom_range(9, 70));
         end else if (sz < 98) begin
            r.page_count = 13'($urandom_range(71, 600));
         end else begin
            r.page_count = 13'($urandom_range(0, 8191));
         end
      end else if (pick < 75) begin
         // free a run handed out earlier, junk in the in-page offset bits
         r.operation = OP_FREE;
         if (live_runs.size() > 0) begin
            idx = $urandom_range(0, live_runs.size() - 1);
            rn  = live_runs[idx];
            live_runs.delete(idx);
            r.byte_address = rn.first_page * BYTES_PER_PAGE
                             + $urandom_range(0, BYTES_PER_PAGE - 1);
            r.page_count   = 13'(rn.pages);
         end else begin
            pg             = $urandom_range(0, NUM_PAGES + 100);
            r.byte_address = pg * BYTES_PER_PAGE + $urandom_range(0, BYTES_PER_PAGE - 1);
            r.page_count   = 13'($urandom_range(1, 100));
         end
      end else if (pick < 88) begin
         // reserve a hole in the map, sometimes past the total
         r.operation    = OP_RESERVE;
         pg             = $urandom_range(0, active_pages() + 8);
         r.byte_address = pg * BYTES_PER_PAGE + $urandom_range(0, BYTES_PER_PAGE - 1);
         r.page_count   = 13'($urandom_range(1, 40));
      end else if (pick < 94) begin
         // free of a stretch that may be partly free already
         r.operation    = OP_FREE;
         pg             = $urandom_range(0, NUM_PAGES + 100);
         r.byte_address = pg * BYTES_PER_PAGE + $urandom_range(0, BYTES_PER_PAGE - 1);
         r.page_count   = 13'($urandom_range(1, 100));
      end else if (pick < 97) begin
         r.operation  = OP_UNKNOWN;
         r.page_count = 13'($urandom());
      end else begin
         // noise: any address, any count
         r.operation  = pick[0] ? OP_FREE : OP_RESERVE;
         r.page_count = 13'($urandom());
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // clock, time limit, main sequence
   // ------------------------------------------------------------------

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // bound far above the slowest correct run
   initial begin
      #(64'd300_000_000);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      dir_row_type row;
      req_type     r;
      bit          burst;
      logic [12:0] tot;

      reset          = 1'b1;
      start          = 1'b0;
      req_item       = '0;
      csr_we         = 1'b0;
      csr_wdata      = '0;
      page_map       = '0;
      mirror_used    = '0;
      total_reg      = '0;
      mismatch_count = 0;

      // total still zero after reset: nothing allocatable, free skips everything
      add_checked(OP_ALLOC,   32'h0000_0000, 13'd1,    24'h0, 1'b0, 13'd0, 13'd0);
      add_checked(OP_FREE,    32'h0000_0000, 13'd1,    24'h0, 1'b1, 13'd0, 13'd0);
      add_checked(OP_UNKNOWN, 32'hFFFF_FFFF, 13'd8191, 24'h0, 1'b0, 13'd0, 13'd0);
      add_cfg(13'd4096);
      // zero-length allocate fails
      add_checked(OP_ALLOC,   32'hFFFF_FFFF, 13'd0,    24'h0,      1'b0, 13'd0,    13'd4096);
      add_checked(OP_ALLOC,   32'h0000_0000, 13'd1,    24'h1000,   1'b1, 13'd1,    13'd4095);
      // no run long enough
      add_checked(OP_ALLOC,   32'h0000_0000, 13'd4096, 24'h0,      1'b0, 13'd1,    13'd4095);
      add_checked(OP_ALLOC,   32'h0000_0000, 13'd4094, 24'h2000,   1'b1, 13'd4095, 13'd1);
      // page zero can still be reserved
      add_checked(OP_RESERVE, 32'h0000_0FFF, 13'd1,    24'h0,      1'b1, 13'd4096, 13'd0);
      // reserving used pages changes nothing
      add_checked(OP_RESERVE, 32'h0000_0000, 13'd8191, 24'h0,      1'b1, 13'd4096, 13'd0);
      // start far past the total: every page skipped
      add_checked(OP_FREE,    32'hFFFF_FFFF, 13'd8191, 24'h0,      1'b1, 13'd4096, 13'd0);
      add_checked(OP_FREE,    32'h0000_2FFF, 13'd3,    24'h0,      1'b1, 13'd4093, 13'd3);
      // freeing a free page changes nothing
      add_checked(OP_FREE,    32'h0000_3000, 13'd1,    24'h0,      1'b1, 13'd4093, 13'd3);
      add_checked(OP_ALLOC,   32'h1234_5678, 13'd3,    24'h2000,   1'b1, 13'd4096, 13'd0);
      add_checked(OP_FREE,    32'h0000_0000, 13'd8191, 24'h0,      1'b1, 13'd0,    13'd4096);
      // total above the map size saturates
      add_cfg(13'd8191);
      add_checked(OP_ALLOC,   32'h0000_0000, 13'd4095, 24'h1000,   1'b1, 13'd4095, 13'd1);
      // page zero is never handed out
      add_checked(OP_ALLOC,   32'h0000_0000, 13'd1,    24'h0,      1'b0, 13'd4095, 13'd1);
      // total lowered under marked pages: they stay counted, free count clamps
      add_cfg(13'd100);
      add_checked(OP_ALLOC,   32'h0000_0000, 13'd1,    24'h0,      1'b0, 13'd4095, 13'd0);
      add_checked(OP_RESERVE, 32'h0000_0000, 13'd1,    24'h0,      1'b1, 13'd4096, 13'd0);
      add_checked(OP_FREE,    32'h0003_2000, 13'd8191, 24'h0,      1'b1, 13'd4046, 13'd0);
      add_checked(OP_ALLOC,   32'h0000_0000, 13'd50,   24'h32000,  1'b1, 13'd4096, 13'd0);
      add_cfg(13'd4096);
      add_checked(OP_FREE,    32'h0000_0000, 13'd4096, 24'h0,      1'b1, 13'd0,    13'd4096);
      add_beat(OP_ALLOC,   32'hA5A5_A5A5, 13'd64);
      add_beat(OP_ALLOC,   32'h5A5A_5A5A, 13'd65);
      add_beat(OP_RESERVE, 32'h0004_1000, 13'd10);
      add_cfg(13'd1);
      add_beat(OP_ALLOC,   32'h0000_0000, 13'd1);
      add_beat(OP_RESERVE, 32'h0000_0000, 13'd2);

      // reset is held from the start, released on a falling edge
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[k]) begin
         row = dir_rows[k];
         if (row.is_cfg) begin
            write_total(row.cfg_value);
         end else begin
            send_beat(row.req, row.typed, row.rsp, $urandom_range(0, MAX_GAP));
         end
      end

      // random phases, one page total each; some run with no idle at all
      for (int ph = 0; ph < PHASES; ph++) begin
         tot = PHASE_TOTAL[ph];
         if (ph == RANDOM_PHASE) begin
            tot = 13'($urandom_range(0, 8191));
         end
         write_total(tot);
         burst = (ph % 3 == 1);
         for (int n = 0; n < PHASE_BEATS; n++) begin
            // flip between idling and back-to-back stretches now and then
            if ($urandom_range(0, 19) == 0) begin
               burst = !burst;
            end
            r = random_req();
            send_beat(r, 1'b0, '0, burst ? 0 : $urandom_range(0, MAX_GAP));
         end
      end

      // drain, then watch a while longer for stray beats
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_rsps.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
